/* hdl/vvd_pkg.sv */
// Package for the varint/varlong decoder: request and result structs,
// status codes and group constants. No dependencies.
package vvd_pkg;

	localparam int unsigned GROUP_BITS  = 7;
	localparam logic [3:0]  SHORT_LIMIT = 4'd5;
	localparam logic [3:0]  LONG_LIMIT  = 4'd10;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LONG  = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       buffer_end;
	} vvd_req_t;

	typedef struct packed {
		logic signed [63:0] decoded_value;
		logic [1:0]         status;
		logic [3:0]         bytes_used;
	} vvd_rsp_t;

endpackage

/* hdl/vvd_step.sv */
// One decode step: merges a stream byte into the running value and decides
// whether a result is due. Depends on vvd_pkg.
module vvd_step (
	input  logic          long_mode,
	input  logic [63:0]   acc,
	input  logic [3:0]    group_count,
	input  vvd_pkg::vvd_req_t req,
	output logic          emit,
	output vvd_pkg::vvd_rsp_t rsp,
	output logic [63:0]   acc_next,
	output logic [3:0]    group_count_next
);
	import vvd_pkg::*;

	logic [3:0]  limit;
	logic [3:0]  used;
	logic [6:0]  shamt;
	logic [63:0] merged;

	assign limit  = long_mode ? LONG_LIMIT : SHORT_LIMIT;
	assign used   = group_count + 4'd1;
	assign shamt  = 7'(group_count) * 7'(GROUP_BITS);
	// group_count stays at or below 9, so the shift tops out at 63
	assign merged = acc | ({57'd0, req.stream_byte[6:0]} << shamt[5:0]);

	always_comb begin
		emit              = 1'b0;
		rsp.decoded_value = '0;
		rsp.status        = ST_OK;
		rsp.bytes_used    = used;
		acc_next          = '0;
		group_count_next  = '0;
		if (group_count >= limit) begin
			// mode lowered while a value was in flight
			emit       = 1'b1;
			rsp.status = ST_TOO_LONG;
		end else if (!req.stream_byte[7]) begin
			emit = 1'b1;
			if (long_mode) begin
				rsp.decoded_value = merged;
			end else begin
				rsp.decoded_value = {{32{merged[31]}}, merged[31:0]};
			end
		end else if (used >= limit) begin
			emit       = 1'b1;
			rsp.status = ST_TOO_LONG;
		end else if (req.buffer_end) begin
			emit       = 1'b1;
			rsp.status = ST_TRUNCATED;
		end else begin
			acc_next         = merged;
			group_count_next = used;
		end
	end

endmodule

/* hdl/varint_varlong_decoder.sv */
// Varint/varlong decoder, one stream byte per request, 7-bit groups
// little-endian. Uses vvd_pkg and vvd_step.
//
// Channels:
//   req  - one stream byte plus a buffer_end flag per request (valid/ready).
//   rsp  - one decoded value, status and byte count per finished value or
//          failed attempt (valid/ready).
//   cfg  - single-bit long_mode register write (valid/ready, always ready).
//          long_mode 0 decodes 32-bit values of up to 5 bytes, sign-extended;
//          1 decodes 64-bit values of up to 10 bytes. Write only when idle.
// Path: a request enters the input register on acceptance; the decode step
//   runs on it once the result register is free or being taken, and a
//   finished value or failed attempt loads the result register onto rsp.
// Throughput: one byte per cycle while rsp is not stalled, with the
//   accumulate and shift into the 64-bit accumulator done combinationally.
// Reset clears long_mode, the accumulator, the group count and both valid
//   flags. When the receiver stalls, the result register holds, the input
//   register fills, and then req_ready drops until rsp is taken.
module varint_varlong_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  vvd_pkg::vvd_req_t  req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output vvd_pkg::vvd_rsp_t  rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import vvd_pkg::*;

	logic        long_mode_q;
	logic [63:0] acc_q;
	logic [3:0]  group_count_q;
	logic        valid_s1;
	vvd_req_t    req_s1;
	logic        rsp_valid_q;
	vvd_rsp_t    rsp_q;

	logic        advance;
	logic        emit;
	vvd_rsp_t    step_rsp;
	logic [63:0] acc_next;
	logic [3:0]  group_count_next;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	vvd_step u_step (
		.long_mode        (long_mode_q),
		.acc              (acc_q),
		.group_count      (group_count_q),
		.req              (req_s1),
		.emit             (emit),
		.rsp              (step_rsp),
		.acc_next         (acc_next),
		.group_count_next (group_count_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			long_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			group_count_q <= '0;
		end else if (advance) begin
			acc_q         <= acc_next;
			group_count_q <= group_count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			// load a new result, else hold an untaken one
			rsp_valid_q <= (advance && emit) || (rsp_valid_q && !rsp_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			rsp_q <= step_rsp;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		group_count_q <= 4'd9)
		else $error("group count beyond nine");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> group_count_q == 4'd0 && acc_q == 64'd0)
		else $error("state not cleared after a result");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != ST_OK |-> rsp_q.decoded_value == 64'sd0)
		else $error("error result carries a nonzero value");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("input register changed while stalled");

endmodule

/* tb/tb_varint_varlong_decoder.sv */
// Self-checking testbench for varint_varlong_decoder: directed and random byte streams in
// both modes, with a decode predictor and a result scoreboard. Depends on vvd_pkg and the
// decoder RTL.
module tb_varint_varlong_decoder;
	import vvd_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	vvd_req_t  req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	vvd_rsp_t  rsp;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;

	vvd_req_t  pending_reqs[$];
	vvd_rsp_t  expected_rsps[$];
	vvd_rsp_t  want;

	// decode predictor state
	logic        dec_long = 1'b0;
	logic [63:0] dec_acc = '0;
	logic [3:0]  dec_groups = '0;

	int  send_gap = 0;
	int  recv_gap = 0;
	int  hold_left = 0;
	logic hold_go = 1'b0;
	bit  idle_on = 1'b1;
	int  fail_count = 0;

	varint_varlong_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic predict_decode(input vvd_req_t r);
		logic [3:0]  limit;
		logic [3:0]  used;
		logic [63:0] v;
		vvd_rsp_t    res;
		limit = dec_long ? LONG_LIMIT : SHORT_LIMIT;
		used = dec_groups + 4'd1;
		res = '0;
		res.bytes_used = used;
		if (dec_groups >= limit) begin
			// mode lowered under a partial value
			res.status = ST_TOO_LONG;
		end else begin
			dec_acc = dec_acc | (64'(r.stream_byte[6:0]) << (GROUP_BITS * dec_groups));
			if (!r.stream_byte[7]) begin
				v = dec_acc;
				if (!dec_long)
					v = {{32{v[31]}}, v[31:0]};
				res.decoded_value = v;
				res.status = ST_OK;
			end else begin
				dec_groups = used;
				if (dec_groups >= limit)
					res.status = ST_TOO_LONG;
				else if (r.buffer_end)
					res.status = ST_TRUNCATED;
				else
					return;
			end
		end
		expected_rsps = {expected_rsps, res};
		dec_acc = '0;
		dec_groups = '0;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap <= 0;
		end else begin
			if (req_valid && req_ready)
				predict_decode(req);
			if (req_valid && !req_ready) begin
				// hold the offered request
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				if (idle_on && $urandom_range(0, 6) == 0)
					send_gap <= $urandom_range(1, 16);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= 300;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected result: decoded_value %0d status %0d bytes_used %0d",
						rsp.decoded_value, rsp.status, rsp.bytes_used);
					fail_count++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.decoded_value !== want.decoded_value) begin
						$error("decoded_value: expected %0d, actual %0d",
							want.decoded_value, rsp.decoded_value);
						fail_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						fail_count++;
					end
					if (rsp.bytes_used !== want.bytes_used) begin
						$error("bytes_used: expected %0d, actual %0d",
							want.bytes_used, rsp.bytes_used);
						fail_count++;
					end
				end
			end
			if (hold_left != 0) begin
				rsp_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					recv_gap <= $urandom_range(1, 16);
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last);
		vvd_req_t r;
		r.stream_byte = b;
		r.buffer_end = last;
		pending_reqs = {pending_reqs, r};
	endtask

	// wait out all requests and results, then the pipeline latency;
	// sample between edges so the driver and monitor have settled
	task automatic settle();
		@(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_long_mode(input logic mode);
		cfg_data <= mode;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		dec_long = mode;
	endtask

	// mostly well-formed values with random groups, plus truncated, overlong and noise bytes
	task automatic queue_stream(input int target, input int limit);
		int n;
		int kind;
		int len;
		int fill;
		bit closed;
		bit end_last;
		logic [6:0] grp;
		n = 0;
		while (n < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				n++;
			end else begin
				if (kind < 72) begin
					len = $urandom_range(1, limit);
					closed = 1'b1;
					end_last = 1'($urandom_range(0, 1));
				end else if (kind < 86) begin
					len = $urandom_range(1, limit - 1);
					closed = 1'b0;
					end_last = 1'b1;
				end else begin
					len = limit;
					closed = 1'b0;
					end_last = 1'($urandom_range(0, 1));
				end
				fill = $urandom_range(0, 5);
				for (int i = 0; i < len; i++) begin
					if (fill == 0)
						grp = 7'h00;
					else if (fill == 1)
						grp = 7'h7F;
					else
						grp = 7'($urandom_range(0, 127));
					queue_byte({(i < len - 1) ? 1'b1 : !closed, grp},
						(i == len - 1) ? end_last : 1'b0);
				end
				n += len;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_long_mode(1'b0);

		// short mode: zero, all-ones with overlong final group and buffer end on it
		queue_byte(8'h00, 1'b0);
		repeat (4) queue_byte(8'hFF, 1'b0);
		queue_byte(8'h7F, 1'b1);
		// too long wins over buffer end
		repeat (4) queue_byte(8'h80, 1'b0);
		queue_byte(8'h80, 1'b1);
		// truncated buffer
		queue_byte(8'h81, 1'b1);
		// leave a partial value, then raise the mode under it
		queue_byte(8'h80, 1'b0);
		settle();
		write_long_mode(1'b1);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h7F, 1'b0);
		// six open groups, then lower the mode under them
		repeat (6) queue_byte(8'h80, 1'b0);
		settle();
		write_long_mode(1'b0);
		queue_byte(8'h00, 1'b0);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			write_long_mode(ph % 2 == 0);
			if (ph == 4)
				idle_on = 1'b0;
			queue_stream(230, (ph % 2 == 0) ? LONG_LIMIT : SHORT_LIMIT);
			if (ph == 2) begin
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			settle();
		end

		if (fail_count == 0)
			$display("varint_varlong_decoder regression: pass");
		else
			$display("varint_varlong_decoder regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("varint_varlong_decoder regression: fail");
		$finish;
	end

endmodule
